// ===== rtl/shp_pkg.sv =====
`timescale 1ns / 1ps
package shp_pkg;

	localparam int PIX_W      = 8;
	localparam int SUM_W      = 13;
	localparam int WIDTH_W    = 11;
	localparam int HEIGHT_W   = 13;
	localparam int ROW_W      = 14;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;
	localparam int OUT_CH     = 3;
	localparam int IN_CH      = 4;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_WIDTH  = 2'd0,
		REG_IMAGE_HEIGHT = 2'd1
	} cfg_reg_t;

	typedef logic [PIX_W-1:0] chan_t;
	typedef logic signed [SUM_W-1:0] sum_t;

	typedef struct packed {
		logic emit;
		logic left_ok;
		logic right_ok;
		logic top_ok;
		logic bot_ok;
		logic row_end;
		logic frame_last;
	} ctl_t;

	function automatic chan_t clamp_sum(sum_t s);
		chan_t r;
		if (s < sum_t'(0))
			r = '0;
		else if (s > sum_t'(255))
			r = '1;
		else
			r = s[PIX_W-1:0];
		return r;
	endfunction

endpackage

// ===== rtl/shp_line_buf.sv =====
`timescale 1ns / 1ps
module shp_line_buf import shp_pkg::*; #(
	parameter int MAX_WIDTH = 1024,
	parameter int CHANNELS  = 3
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          rd_en,
	input  logic [$clog2(MAX_WIDTH)-1:0]  rd_addr,
	input  logic                          wr_en,
	input  logic [$clog2(MAX_WIDTH)-1:0]  wr_addr,
	input  logic [CHANNELS*PIX_W-1:0]     new_pix,
	output logic [CHANNELS*PIX_W-1:0]     above,
	output logic [CHANNELS*PIX_W-1:0]     cur
);

	localparam int PW = CHANNELS * PIX_W;

	logic [2*PW-1:0] mem [MAX_WIDTH];
	logic [2*PW-1:0] rd_q;
	logic [2*PW-1:0] fwd_data_q;
	logic            fwd_q;
	logic [2*PW-1:0] word;
	logic [2*PW-1:0] wr_data;

	// bypass the write that lands in the same cycle as the read
	assign word    = fwd_q ? fwd_data_q : rd_q;
	assign above   = word[2*PW-1:PW];
	assign cur     = word[PW-1:0];
	assign wr_data = {cur, new_pix};

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		if (rd_en) begin
			rd_q       <= mem[rd_addr];
			fwd_data_q <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			fwd_q <= 1'b0;
		else if (rd_en)
			fwd_q <= wr_en && (wr_addr == rd_addr);
	end

endmodule

// ===== rtl/shp_lane.sv =====
`timescale 1ns / 1ps
module shp_lane import shp_pkg::*; (
	input  logic  clk,
	input  logic  en,
	input  chan_t taps [3][3],
	input  ctl_t  ctl,
	output sum_t  sum_s3
);

	logic [11:0] pos;
	logic [10:0] neg;
	logic [2:0]  row_ok;
	chan_t       nb [8];

	assign row_ok = {ctl.bot_ok, 1'b1, ctl.top_ok};

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			nb[k]     = (ctl.left_ok && row_ok[k]) ? taps[0][k] : '0;
			nb[3 + k] = (ctl.right_ok && row_ok[k]) ? taps[2][k] : '0;
		end
		nb[6] = ctl.top_ok ? taps[1][0] : '0;
		nb[7] = ctl.bot_ok ? taps[1][2] : '0;
		pos   = {1'b0, taps[1][1], 3'b000} + 12'(taps[1][1]);
		neg   = '0;
		for (int k = 0; k < 8; k++)
			neg = neg + 11'(nb[k]);
	end

	always_ff @(posedge clk) begin
		if (en)
			sum_s3 <= sum_t'({1'b0, pos}) - sum_t'({2'b00, neg});
	end

endmodule

// ===== rtl/shp_merge.sv =====
`timescale 1ns / 1ps
module shp_merge import shp_pkg::*; #(
	parameter int CHANNELS = 3
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  load,
	input  logic  take,
	input  sum_t  sums [CHANNELS],
	input  ctl_t  ctl,
	output logic  out_valid,
	output chan_t out_blue,
	output chan_t out_green,
	output chan_t out_red,
	output logic  row_end,
	output logic  frame_last
);

	chan_t res_q [OUT_CH];
	logic  valid_q;
	logic  row_end_q;
	logic  frame_last_q;

	for (genvar z = 0; z < OUT_CH; z++) begin : g_out
		if (z < CHANNELS) begin : g_ch
			always_ff @(posedge clk) begin
				if (load)
					res_q[z] <= clamp_sum(sums[z]);
			end
		end else begin : g_zero
			assign res_q[z] = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			row_end_q    <= ctl.row_end;
			frame_last_q <= ctl.frame_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (load)
			valid_q <= take;
	end

	assign out_valid  = valid_q;
	assign out_blue   = res_q[0];
	assign out_green  = res_q[1];
	assign out_red    = res_q[2];
	assign row_end    = row_end_q;
	assign frame_last = frame_last_q;

endmodule

// ===== rtl/sharpen_3x3_rgb_stream.sv =====
`timescale 1ns / 1ps
// 3x3 sharpening filter (nine times the centre minus the eight neighbours, clamped to
// 0..255) on each colour channel of a raster-order pixel stream, with a zero border.
// One transaction is taken per clock while in_stall is low; a result passes through
// the registered pipeline of line-buffer read, window, lane sum and output
// register. The result for a pixel comes out with the input transaction one row plus
// one pixel later, so after the last pixel of a frame image_width + 1 flush
// transactions (cmd = 1) drain the rest. The line buffer is one memory of MAX_WIDTH
// words holding the two previous rows; it needs no clearing after reset. Write
// image_width and image_height only while the block is idle.
module sharpen_3x3_rgb_stream import shp_pkg::*; #(
	parameter int MAX_WIDTH = 1024,
	parameter int CHANNELS  = 3
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  cmd,
	input  chan_t                 in_blue,
	input  chan_t                 in_green,
	input  chan_t                 in_red,
	output logic                  out_valid,
	input  logic                  out_stall,
	output chan_t                 out_blue,
	output chan_t                 out_green,
	output chan_t                 out_red,
	output logic                  row_end,
	output logic                  frame_last
);

	localparam int AW = $clog2(MAX_WIDTH);
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int PW = CHANNELS * PIX_W;

	logic [WIDTH_W-1:0]  width_q;
	logic [HEIGHT_W-1:0] height_q;
	logic [WW-1:0]       w_eff;
	logic [ROW_W-1:0]    h_eff;
	logic [ROW_W-1:0]    h_p1;
	logic [ROW_W-1:0]    h_p2;

	logic [AW-1:0]       col_q;
	logic [ROW_W-1:0]    row_q;
	logic                wrap;
	logic [AW-1:0]       col_c;
	logic [ROW_W-1:0]    row_c;
	logic [AW-1:0]       col_n;
	logic [ROW_W-1:0]    row_n;
	logic                e0;
	logic                e1;
	logic                pix_ok;
	logic                frame_done;
	ctl_t                ctl_in;
	logic [IN_CH-1:0][PIX_W-1:0]    in_ch;
	logic [CHANNELS-1:0][PIX_W-1:0] pix_in;

	logic                out_ready;
	logic                go1, go2, go3;
	logic                free1, free2, free3;
	logic                accept;

	logic                valid_s1, valid_s2, valid_s3;
	logic [AW-1:0]       col_s1;
	logic [CHANNELS-1:0][PIX_W-1:0] pix_s1;
	ctl_t                ctl_s1, ctl_s2, ctl_s3;

	logic [PW-1:0]       lb_above;
	logic [PW-1:0]       lb_cur;
	chan_t               win_q [3][3][CHANNELS];
	sum_t                sums [CHANNELS];

	// configuration
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_W'(640);
			height_q <= HEIGHT_W'(480);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_IMAGE_WIDTH:  width_q  <= cfg_data[WIDTH_W-1:0];
				REG_IMAGE_HEIGHT: height_q <= cfg_data[HEIGHT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (width_q == '0)
			w_eff = WW'(1);
		else if (32'(width_q) > 32'(MAX_WIDTH))
			w_eff = WW'(MAX_WIDTH);
		else
			w_eff = WW'(width_q);
		h_eff = (height_q == '0) ? ROW_W'(1) : ROW_W'(height_q);
		h_p1  = h_eff + ROW_W'(1);
		h_p2  = h_eff + ROW_W'(2);
	end

	// position of the incoming transaction and what it emits
	always_comb begin
		wrap   = WW'(col_q) >= w_eff;
		col_c  = wrap ? '0 : col_q;
		row_c  = wrap ? row_q + ROW_W'(1) : row_q;
		e0     = (col_c == '0) && (row_c >= ROW_W'(2)) && (row_c < h_p2);
		e1     = (col_c != '0) && (row_c >= ROW_W'(1)) && (row_c <= h_eff);
		pix_ok = !cmd && (row_c < h_eff);
		frame_done = (col_c == '0) && (row_c >= h_p1);

		ctl_in.emit       = e0 || e1;
		ctl_in.left_ok    = e0 ? (w_eff >= WW'(2)) : (col_c >= AW'(2));
		ctl_in.right_ok   = !e0;
		ctl_in.top_ok     = e0 ? (row_c >= ROW_W'(3)) : (row_c >= ROW_W'(2));
		ctl_in.bot_ok     = e0 ? (row_c <= h_eff) : (row_c < h_eff);
		ctl_in.row_end    = e0;
		ctl_in.frame_last = e0 && (row_c == h_p1);

		if (frame_done) begin
			col_n = '0;
			row_n = '0;
		end else if ((WW'(col_c) + WW'(1)) >= w_eff) begin
			col_n = '0;
			row_n = row_c + ROW_W'(1);
		end else begin
			col_n = col_c + AW'(1);
			row_n = row_c;
		end
	end

	assign in_ch = {PIX_W'(0), in_red, in_green, in_blue};

	always_comb begin
		for (int z = 0; z < CHANNELS; z++)
			pix_in[z] = pix_ok ? in_ch[z] : '0;
	end

	// pipeline flow
	assign out_ready = !out_valid || !out_stall;
	assign go3       = valid_s3 && (!ctl_s3.emit || out_ready);
	assign free3     = !valid_s3 || go3;
	assign go2       = valid_s2 && free3;
	assign free2     = !valid_s2 || go2;
	assign go1       = valid_s1 && free2;
	assign free1     = !valid_s1 || go1;
	assign accept    = in_valid && free1;
	assign in_stall  = !free1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			col_q    <= '0;
			row_q    <= '0;
			win_q    <= '{default: '0};
		end else begin
			if (free1)
				valid_s1 <= in_valid;
			if (free2)
				valid_s2 <= valid_s1;
			if (free3)
				valid_s3 <= valid_s2;
			if (accept) begin
				col_q <= col_n;
				row_q <= row_n;
			end
			if (go1) begin
				for (int z = 0; z < CHANNELS; z++) begin
					for (int r = 0; r < 3; r++) begin
						win_q[0][r][z] <= win_q[1][r][z];
						win_q[1][r][z] <= win_q[2][r][z];
					end
					win_q[2][0][z] <= lb_above[z*PIX_W +: PIX_W];
					win_q[2][1][z] <= lb_cur[z*PIX_W +: PIX_W];
					win_q[2][2][z] <= pix_s1[z];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (free1) begin
			col_s1 <= col_c;
			pix_s1 <= pix_in;
			ctl_s1 <= ctl_in;
		end
		if (free2)
			ctl_s2 <= ctl_s1;
		if (free3)
			ctl_s3 <= ctl_s2;
	end

	shp_line_buf #(
		.MAX_WIDTH (MAX_WIDTH),
		.CHANNELS  (CHANNELS)
	) u_line_buf (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (free1),
		.rd_addr (col_c),
		.wr_en   (go1),
		.wr_addr (col_s1),
		.new_pix (pix_s1),
		.above   (lb_above),
		.cur     (lb_cur)
	);

	for (genvar z = 0; z < CHANNELS; z++) begin : g_lane
		chan_t taps [3][3];

		always_comb begin
			for (int c = 0; c < 3; c++)
				for (int r = 0; r < 3; r++)
					taps[c][r] = win_q[c][r][z];
		end

		shp_lane u_lane (
			.clk    (clk),
			.en     (free3),
			.taps   (taps),
			.ctl    (ctl_s2),
			.sum_s3 (sums[z])
		);
	end

	shp_merge #(
		.CHANNELS (CHANNELS)
	) u_merge (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (out_ready),
		.take       (go3 && ctl_s3.emit),
		.sums       (sums),
		.ctl        (ctl_s3),
		.out_valid  (out_valid),
		.out_blue   (out_blue),
		.out_green  (out_green),
		.out_red    (out_red),
		.row_end    (row_end),
		.frame_last (frame_last)
	);

endmodule
